>>> design/ame_lp_weight_generator_unit_assert.svh
// Assertion macros for the weight generator; clk_i and rst_ni are taken from the
// module that uses them.
`ifndef AME_LP_WEIGHT_GENERATOR_UNIT_ASSERT_SVH
`define AME_LP_WEIGHT_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ALWG_ASSERT_NOW(name, cond, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define ALWG_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> design/alwg_pkg.sv
package alwg_pkg;

  localparam int MAX_WEIGHT_LEN_DEF = 1024;
  localparam int RAMP_LEN_DEF       = 14;
  // Range of read_index and of relative sample positions.
  localparam int IDX_SPAN           = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int WIN_W      = 26;
  localparam int NUM_W      = 42;
  localparam int REM_W      = 17;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [23:0] POS_MAX = 24'hFF_FFFF;

  localparam logic [23:0] SIGNAL_LENGTH_RST = 24'd16000;
  localparam logic [15:0] FRAME_COUNT_RST   = 16'd100;
  localparam logic [9:0]  FRAME_LENGTH_RST  = 10'd400;
  localparam logic [5:0]  LP_ORDER_RST      = 6'd30;
  localparam logic [16:0] POS_QUOT_RST      = 17'd3277;
  localparam logic [16:0] DUR_QUOT_RST      = 17'd45875;

  typedef enum logic [2:0] {
    REG_SIGNAL_LENGTH = 3'd0,
    REG_FRAME_COUNT   = 3'd1,
    REG_FRAME_LENGTH  = 3'd2,
    REG_LP_ORDER      = 3'd3,
    REG_POS_QUOT      = 3'd4,
    REG_DUR_QUOT      = 3'd5
  } alwg_reg_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_GCI   = 2'd1,
    OP_READ  = 2'd2
  } alwg_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_MUL,
    ST_DLOAD,
    ST_GCHK,
    ST_GMUL,
    ST_GSPAN,
    ST_FILL,
    ST_RD1,
    ST_RD2
  } alwg_state_e;

endpackage

>>> design/alwg_if.sv
interface alwg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] frame_number;
  logic [23:0] gci_position;
  logic [9:0]  read_index;

  modport source(output valid, output opcode, output frame_number, output gci_position,
                 output read_index, input ready);
  modport sink(input valid, input opcode, input frame_number, input gci_position,
               input read_index, output ready);
endinterface

interface alwg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] weight_value;

  modport source(output valid, output weight_value, input ready);
  modport sink(input valid, input weight_value, output ready);
endinterface

>>> design/alwg_ram.sv
module alwg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ame_lp_weight_generator_unit.sv
// LP weighting window generator driven by glottal closure instants.
// Input channel in_i carries one command per transfer: start frame, closure
// instant or read weight. Output channel out_o returns one Q1.15 weight for
// each read command; no other command produces a transfer.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write it only while idle, which the block itself does not enforce.
// Steps per command after it is accepted:
//   start frame:     the zeroing sweep of the weight RAM (one entry per cycle);
//                    the 42-step center divider runs under that sweep.
//   closure instant: ends at the check when dropped or first in the frame, else
//                    a ramp multiply, a span setup and a fill of one sample per
//                    cycle over t1 samples when t1 >= RAMP_LEN, else up to
//                    2*RAMP_LEN - t1, as the ramp-down then reaches back before
//                    the span start; writes stop at the weight length.
//   read weight:     a registered RAM read loads the output register, where the
//                    result sits while the next command is taken.
// Reset runs the same zeroing sweep with in_i.ready low. A stalled receiver
// holds up only a read command, in ST_RD2, until the output register frees up.
module ame_lp_weight_generator_unit #(
  parameter int MAX_WEIGHT_LEN = alwg_pkg::MAX_WEIGHT_LEN_DEF,
  parameter int RAMP_LEN       = alwg_pkg::RAMP_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  alwg_in_if.sink                          in_i,
  alwg_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [alwg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [alwg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  `include "ame_lp_weight_generator_unit_assert.svh"

  localparam int AW    = $clog2(MAX_WEIGHT_LEN);
  localparam int LimW  = $clog2(MAX_WEIGHT_LEN + 1);
  localparam int SpanW = $clog2(alwg_pkg::IDX_SPAN + RAMP_LEN + 1);
  localparam int CW    = (LimW > SpanW) ? LimW : SpanW;
  localparam int RW    = (RAMP_LEN > 0) ? $clog2(RAMP_LEN + 1) : 1;
  localparam int NW    = alwg_pkg::NUM_W;
  localparam int QW    = alwg_pkg::REM_W;
  localparam int WW    = alwg_pkg::WIN_W;

  // Ramp levels round(32768*k/(RAMP_LEN+1)).
  logic [15:0] ramp_tab [RAMP_LEN+1];
  for (genvar k = 0; k <= RAMP_LEN; k++) begin : g_ramp
    localparam int unsigned RampV = (65536 * k + (RAMP_LEN + 1)) / (2 * (RAMP_LEN + 1));
    assign ramp_tab[k] = 16'(RampV);
  end

  alwg_pkg::alwg_state_e state_q, state_d;

  logic [23:0] sl_q, sl_d;
  logic [15:0] fc_q, fc_d;
  logic [9:0]  fl_q, fl_d;
  logic [5:0]  lo_q, lo_d;
  logic [16:0] pq_q, pq_d;
  logic [16:0] dq_q, dq_d;

  logic          out_valid_q, out_valid_d;
  logic [15:0]   weight_q, weight_d;
  logic [1:0]    seen_q, seen_d;
  logic [10:0]   prev_q, prev_d;
  logic [WW-1:0] win_low_q, win_low_d, win_high_q, win_high_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          div_busy_q, div_busy_d;
  logic          win_pend_q, win_pend_d;
  logic [5:0]    div_cnt_q, div_cnt_d;

  logic [15:0]   fn_q, fn_d;
  logic [39:0]   prod_q, prod_d;
  logic [NW-1:0] nq_q, nq_d;
  logic [QW-1:0] rem_q, rem_d;
  logic [23:0]   g_q, g_d;
  logic [9:0]    rd_idx_q, rd_idx_d;
  logic [10:0]   t_q, t_d, base_q, base_d, t1_q, t1_d, t2_q, t2_d;
  logic [CW-1:0] j_q, j_d, s_q, s_d, e_q, e_d, end_q, end_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic          in_acc;
  logic [15:0]   fc_eff;
  logic [QW-1:0] den;
  logic [QW:0]   trial;
  logic [23:0]   centre;
  logic [WW-1:0] half_w, gs, rel_w;
  logic          in_win;
  logic [16:0]   pq_c, dq_c;
  logic [27:0]   p1, p2;
  logic [11:0]   t_sum;
  logic [10:0]   t1_adj;
  logic [CW-1:0] s_c, e_c, up_end, end_c, wl, sum_lim, idx_ext, n_up, n_dn;
  logic [CW-1:0] dn_lo, j0_c;
  logic          up_hit, dn_hit;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == alwg_pkg::ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.weight_value = weight_q;

  assign fc_eff = (fc_q == 16'd0) ? 16'd1 : fc_q;
  assign den    = {fc_eff, 1'b0};
  assign trial  = {rem_q, nq_q[NW-1]};
  assign centre = (nq_q[NW-1:24] != '0) ? alwg_pkg::POS_MAX : nq_q[23:0];
  assign half_w = WW'(fl_q[9:1]);
  assign gs     = WW'(g_q);
  assign in_win = ($signed(gs) >= $signed(win_low_q)) && ($signed(gs) <= $signed(win_high_q));
  assign rel_w  = gs - win_low_q;

  assign pq_c = (pq_q > alwg_pkg::Q16_ONE) ? alwg_pkg::Q16_ONE : pq_q;
  assign dq_c = (dq_q > (alwg_pkg::Q16_ONE - pq_c)) ? (alwg_pkg::Q16_ONE - pq_c) : dq_q;
  assign p1   = dq_c * t_q + 28'd32768;
  assign p2   = pq_c * t_q + 28'd32768;

  assign t_sum  = {1'b0, t1_q} + {1'b0, t2_q};
  assign t1_adj = (t_sum > {1'b0, t_q}) ? (t_q - t2_q) : t1_q;
  assign s_c    = CW'(base_q) + CW'(t2_q);
  assign e_c    = s_c + CW'(t1_adj);
  assign up_end = s_c + CW'(RAMP_LEN);
  assign end_c  = (e_c > up_end) ? e_c : up_end;
  // A short span lets the ramp-down start before the span itself.
  assign dn_lo  = e_c - CW'(RAMP_LEN);
  assign j0_c   = ((e_c >= CW'(RAMP_LEN)) && (dn_lo < s_c)) ? dn_lo : s_c;

  assign sum_lim = CW'(fl_q) + CW'(lo_q);
  assign wl      = (sum_lim < CW'(MAX_WEIGHT_LEN)) ? sum_lim : CW'(MAX_WEIGHT_LEN);
  assign idx_ext = CW'(rd_idx_q);

  assign up_hit = j_q < (s_q + CW'(RAMP_LEN));
  assign dn_hit = (e_q >= CW'(RAMP_LEN)) && (j_q >= (e_q - CW'(RAMP_LEN))) && (j_q < e_q);
  assign n_up   = j_q - s_q + CW'(1);
  assign n_dn   = e_q - j_q;

  always_comb begin
    state_d    = state_q;
    sl_d = sl_q; fc_d = fc_q; fl_d = fl_q; lo_d = lo_q; pq_d = pq_q; dq_d = dq_q;
    out_valid_d = out_valid_q && !out_o.ready;
    weight_d   = weight_q;
    seen_d     = seen_q;
    prev_d     = prev_q;
    win_low_d  = win_low_q;
    win_high_d = win_high_q;
    clr_cnt_d  = clr_cnt_q;
    div_busy_d = div_busy_q;
    win_pend_d = win_pend_q;
    div_cnt_d  = div_cnt_q;
    fn_d = fn_q; prod_d = prod_q; nq_d = nq_q; rem_d = rem_q; g_d = g_q;
    rd_idx_d = rd_idx_q; t_d = t_q; base_d = base_q; t1_d = t1_q; t2_d = t2_q;
    j_d = j_q; s_d = s_q; e_d = e_q; end_d = end_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = j_q[AW-1:0];
    ram_wdata = alwg_pkg::ONE_Q15;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        alwg_pkg::REG_SIGNAL_LENGTH: sl_d = cfg_data_i;
        alwg_pkg::REG_FRAME_COUNT:   fc_d = cfg_data_i[15:0];
        alwg_pkg::REG_FRAME_LENGTH:  fl_d = cfg_data_i[9:0];
        alwg_pkg::REG_LP_ORDER:      lo_d = cfg_data_i[5:0];
        alwg_pkg::REG_POS_QUOT:      pq_d = cfg_data_i[16:0];
        alwg_pkg::REG_DUR_QUOT:      dq_d = cfg_data_i[16:0];
        default: ;
      endcase
    end

    case (state_q)
      alwg_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_i.opcode)
            alwg_pkg::OP_START: begin
              fn_d    = in_i.frame_number;
              seen_d  = 2'd0;
              prev_d  = '0;
              state_d = alwg_pkg::ST_MUL;
            end
            alwg_pkg::OP_GCI: begin
              g_d     = in_i.gci_position;
              state_d = alwg_pkg::ST_GCHK;
            end
            alwg_pkg::OP_READ: begin
              rd_idx_d = in_i.read_index;
              state_d  = alwg_pkg::ST_RD1;
            end
            default: ;
          endcase
        end
      end
      alwg_pkg::ST_MUL: begin
        prod_d  = sl_q * fn_q;
        state_d = alwg_pkg::ST_DLOAD;
      end
      alwg_pkg::ST_DLOAD: begin
        nq_d       = {prod_q, 1'b0} + NW'(fc_eff);
        rem_d      = '0;
        div_cnt_d  = '0;
        div_busy_d = 1'b1;
        win_pend_d = 1'b1;
        clr_cnt_d  = '0;
        state_d    = alwg_pkg::ST_CLR;
      end
      alwg_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        // one restoring divide step per cycle under the sweep
        if (div_busy_q) begin
          if (trial >= {1'b0, den}) begin
            rem_d = QW'(trial - {1'b0, den});
            nq_d  = {nq_q[NW-2:0], 1'b1};
          end else begin
            rem_d = trial[QW-1:0];
            nq_d  = {nq_q[NW-2:0], 1'b0};
          end
          div_cnt_d = div_cnt_q + 6'd1;
          if (div_cnt_q == 6'(NW - 1)) begin
            div_busy_d = 1'b0;
          end
        end
        if (clr_cnt_q == AW'(MAX_WEIGHT_LEN - 1)) begin
          state_d = alwg_pkg::ST_IDLE;
          if (win_pend_q) begin
            win_pend_d = 1'b0;
            win_low_d  = WW'(centre) - half_w;
            win_high_d = WW'(centre) + half_w - WW'(1);
          end
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      alwg_pkg::ST_GCHK: begin
        state_d = alwg_pkg::ST_IDLE;
        // drop out-of-window and non-ascending instants
        if (in_win && !((seen_q != 2'd0) && (rel_w[10:0] <= prev_q))) begin
          base_d = prev_q;
          t_d    = rel_w[10:0] - prev_q;
          prev_d = rel_w[10:0];
          if (seen_q != 2'd2) begin
            seen_d = seen_q + 2'd1;
          end
          if (seen_q != 2'd0) begin
            state_d = alwg_pkg::ST_GMUL;
          end
        end
      end
      alwg_pkg::ST_GMUL: begin
        t1_d    = p1[26:16];
        t2_d    = p2[26:16];
        state_d = alwg_pkg::ST_GSPAN;
      end
      alwg_pkg::ST_GSPAN: begin
        s_d   = s_c;
        e_d   = e_c;
        end_d = end_c;
        j_d   = j0_c;
        state_d = (end_c > j0_c) ? alwg_pkg::ST_FILL : alwg_pkg::ST_IDLE;
      end
      alwg_pkg::ST_FILL: begin
        // ramp-down wins over ramp-up, both over the flat part
        if (dn_hit) begin
          ram_wdata = ramp_tab[n_dn[RW-1:0]];
        end else if (up_hit) begin
          ram_wdata = ramp_tab[n_up[RW-1:0]];
        end
        ram_we = (j_q < wl);
        j_d    = j_q + CW'(1);
        if ((j_q + CW'(1)) == end_q) begin
          state_d = alwg_pkg::ST_IDLE;
        end
      end
      alwg_pkg::ST_RD1: begin
        ram_re  = 1'b1;
        state_d = alwg_pkg::ST_RD2;
      end
      alwg_pkg::ST_RD2: begin
        ram_re = 1'b1;
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          if (seen_q == 2'd0) begin
            weight_d = alwg_pkg::ONE_Q15;
          end else if (idx_ext < CW'(MAX_WEIGHT_LEN)) begin
            weight_d = ram_rdata;
          end else begin
            weight_d = '0;
          end
          state_d = alwg_pkg::ST_IDLE;
        end
      end
      default: state_d = alwg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alwg_pkg::ST_CLR;
      sl_q        <= alwg_pkg::SIGNAL_LENGTH_RST;
      fc_q        <= alwg_pkg::FRAME_COUNT_RST;
      fl_q        <= alwg_pkg::FRAME_LENGTH_RST;
      lo_q        <= alwg_pkg::LP_ORDER_RST;
      pq_q        <= alwg_pkg::POS_QUOT_RST;
      dq_q        <= alwg_pkg::DUR_QUOT_RST;
      out_valid_q <= 1'b0;
      seen_q      <= 2'd0;
      prev_q      <= '0;
      win_low_q   <= '0;
      win_high_q  <= '0;
      clr_cnt_q   <= '0;
      div_busy_q  <= 1'b0;
      win_pend_q  <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      sl_q        <= sl_d;
      fc_q        <= fc_d;
      fl_q        <= fl_d;
      lo_q        <= lo_d;
      pq_q        <= pq_d;
      dq_q        <= dq_d;
      out_valid_q <= out_valid_d;
      seen_q      <= seen_d;
      prev_q      <= prev_d;
      win_low_q   <= win_low_d;
      win_high_q  <= win_high_d;
      clr_cnt_q   <= clr_cnt_d;
      div_busy_q  <= div_busy_d;
      win_pend_q  <= win_pend_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q <= weight_d;
    fn_q     <= fn_d;
    prod_q   <= prod_d;
    nq_q     <= nq_d;
    rem_q    <= rem_d;
    g_q      <= g_d;
    rd_idx_q <= rd_idx_d;
    t_q      <= t_d;
    base_q   <= base_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    j_q      <= j_d;
    s_q      <= s_d;
    e_q      <= e_d;
    end_q    <= end_d;
  end

  alwg_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WEIGHT_LEN)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_ext[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  `ALWG_ASSERT_NOW(a_div_before_sweep_end,
    (state_q == alwg_pkg::ST_CLR) && (clr_cnt_q == AW'(MAX_WEIGHT_LEN - 1)), !div_busy_q,
    "center divide still running at end of sweep")
  `ALWG_ASSERT_NOW(a_fill_in_limit, ram_we && (state_q == alwg_pkg::ST_FILL), j_q < wl,
    "span write beyond weight length")
  `ALWG_ASSERT_NOW(a_seen_sat, 1'b1, seen_q != 2'd3, "closure count past saturation")
  `ALWG_ASSERT_NEXT(a_read_lands, (state_q == alwg_pkg::ST_RD2) && !out_valid_q,
    out_valid_q && (state_q == alwg_pkg::ST_IDLE), "read result not loaded")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import alwg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         STORE_LEN = 1024;
  localparam int         RAMP      = 14;
  localparam int         SETTLE    = 1200;
  localparam longint     CYCLE_LIMIT = 4000000;
  localparam int         TARGET_ITEMS = 1350;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] fn;
    logic [23:0] gci;
    logic [9:0]  ridx;
  } cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  alwg_in_if  in_ch ();
  alwg_out_if out_ch ();

  ame_lp_weight_generator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Weight model state and its own copy of the configuration.
  longint unsigned sig_len, frm_cnt, frm_len, lp_ord, pos_q, dur_q;
  logic [15:0] wstore [STORE_LEN];
  longint win_lo, win_hi, prev_gci;
  int     gci_seen;

  cmd_t        pend_cmds[$];
  logic [15:0] weights_due[$];
  int          mismatches = 0;
  int          n_items = 0;
  longint      cycles = 0;
  logic        in_fire = 1'b0;
  int          burst_left = 0, gap_left = 0;
  int          stall_mode = 0, stall_left = 0, mode_left = 0;

  function automatic longint frame_low(logic [15:0] fn);
    longint unsigned fc, ctr;
    fc  = (frm_cnt == 0) ? 1 : frm_cnt;
    ctr = (2 * sig_len * fn + fc) / (2 * fc);
    if (ctr > POS_MAX) ctr = POS_MAX;
    return longint'(ctr) - longint'(frm_len / 2);
  endfunction

  function automatic logic [15:0] ramp_q15(int unsigned num);
    return 16'((2 * num * 32768 + (RAMP + 1)) / (2 * (RAMP + 1)));
  endfunction

  function automatic void put_weight(longint idx, logic [15:0] v);
    longint lim;
    lim = longint'(frm_len + lp_ord);
    if (lim > STORE_LEN) lim = STORE_LEN;
    if (idx >= 0 && idx < lim) wstore[idx] = v;
  endfunction

  function automatic void fill_span(longint prev, longint cur);
    longint unsigned t, pq, dq, t1, t2;
    longint s, e;
    t  = longint'(cur - prev);
    pq = (pos_q > 65536) ? 65536 : pos_q;
    dq = (dur_q > 65536 - pq) ? 65536 - pq : dur_q;
    t1 = (dq * t + 32768) >> 16;
    t2 = (pq * t + 32768) >> 16;
    if (t1 + t2 > t) t1 = t - t2;
    s = prev + longint'(t2);
    e = s + longint'(t1);
    for (longint j = s; j < e; j++) put_weight(j, ONE_Q15);
    for (int j = 0; j < RAMP; j++) put_weight(s + j, ramp_q15(j + 1));
    if (e - RAMP >= 0)
      for (int j = 0; j < RAMP; j++) put_weight(e - RAMP + j, ramp_q15(RAMP - j));
  endfunction

  function automatic void predict_weight(cmd_t c);
    longint g, rel;
    case (c.op)
      OP_START: begin
        win_lo = frame_low(c.fn);
        win_hi = win_lo + 2 * longint'(frm_len / 2) - 1;
        foreach (wstore[i]) wstore[i] = '0;
        prev_gci = 0;
        gci_seen = 0;
      end
      OP_GCI: begin
        g = longint'(c.gci);
        if (g >= win_lo && g <= win_hi) begin
          rel = g - win_lo;
          if (gci_seen == 0 || rel > prev_gci) begin
            if (gci_seen > 0) fill_span(prev_gci, rel);
            prev_gci = rel;
            if (gci_seen < 2) gci_seen++;
          end
        end
      end
      OP_READ: weights_due.push_back(gci_seen == 0 ? ONE_Q15 : wstore[c.ridx]);
      default: ;
    endcase
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_SIGNAL_LENGTH: sig_len = d;
      REG_FRAME_COUNT:   frm_cnt = d[15:0];
      REG_FRAME_LENGTH:  frm_len = d[9:0];
      REG_LP_ORDER:      lp_ord  = d[5:0];
      REG_POS_QUOT:      pos_q   = d[16:0];
      REG_DUR_QUOT:      dur_q   = d[16:0];
      default: ;
    endcase
  endfunction

  // Sample both channels and the config port.
  always @(posedge clk_i) begin : mon
    cmd_t c;
    logic [15:0] want;
    cycles <= cycles + 1;
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && cfg_we_i) apply_cfg(cfg_idx_i, cfg_data_i);
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      c.op = in_ch.opcode; c.fn = in_ch.frame_number;
      c.gci = in_ch.gci_position; c.ridx = in_ch.read_index;
      predict_weight(c);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (weights_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected weight %0d", out_ch.weight_value);
      end else begin
        want = weights_due.pop_front();
        if (out_ch.weight_value !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("weight mismatch: expected %0d, got %0d", want, out_ch.weight_value);
        end
      end
    end
  end

  // Command driver: bursts of transfers separated by random gaps.
  always @(negedge clk_i) begin : drv
    cmd_t c;
    if (rst_ni && (!in_ch.valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pend_cmds.size() > 0) begin
        c = pend_cmds.pop_front();
        in_ch.opcode <= c.op;
        in_ch.frame_number <= c.fn;
        in_ch.gci_position <= c.gci;
        in_ch.read_index <= c.ridx;
        in_ch.valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: switch between always ready, random, and long stalls.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end
    mode_left--;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 24);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] op, logic [15:0] fn, logic [23:0] g, logic [9:0] ri);
    cmd_t c;
    c.op = op; c.fn = fn; c.gci = g; c.ridx = ri;
    pend_cmds.push_back(c);
    if (op != OP_UNUSED) n_items++;
  endtask

  task automatic wait_idle();
    while (pend_cmds.size() > 0 || in_ch.valid || weights_due.size() > 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_cfg(alwg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_all(logic [23:0] sl, logic [15:0] fc, logic [9:0] fl, logic [5:0] lp,
                         logic [16:0] pq, logic [16:0] dq);
    wait_idle();
    write_cfg(REG_SIGNAL_LENGTH, sl);
    write_cfg(REG_FRAME_COUNT, 24'(fc));
    write_cfg(REG_FRAME_LENGTH, 24'(fl));
    write_cfg(REG_LP_ORDER, 24'(lp));
    write_cfg(REG_POS_QUOT, 24'(pq));
    write_cfg(REG_DUR_QUOT, 24'(dq));
  endtask

  // One frame: start, a mostly well-formed ascending GCI train, at times an unused opcode, reads.
  task automatic gen_frame();
    logic [15:0] fn;
    longint lo, wsz, pos, g;
    int pmax, ngci, nrd, wlen;
    fn = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, frm_cnt));
    push_cmd(OP_START, fn, 24'($urandom), 10'($urandom));
    lo = frame_low(fn);
    wsz = 2 * longint'(frm_len / 2);
    pmax = (wsz > 4) ? $urandom_range(2, int'(wsz / 2) + 1) : 2;
    ngci = $urandom_range(0, 7);
    pos = $urandom_range(0, pmax);
    for (int i = 0; i < ngci; i++) begin
      g = lo + pos;
      if ($urandom_range(0, 9) == 0 || g < 0 || g > POS_MAX) push_cmd(OP_GCI, '0, 24'($urandom), '0);
      else push_cmd(OP_GCI, 16'($urandom), 24'(g), 10'($urandom));
      if ($urandom_range(0, 12) == 0) push_cmd(OP_GCI, '0, 24'(g), '0);
      pos += $urandom_range(1, pmax);
    end
    if ($urandom_range(0, 15) == 0) push_cmd(OP_UNUSED, 16'($urandom), 24'($urandom), 10'($urandom));
    wlen = int'(frm_len + lp_ord);
    if (wlen > STORE_LEN) wlen = STORE_LEN;
    if (wlen < 1) wlen = 1;
    nrd = $urandom_range(6, 20);
    for (int i = 0; i < nrd; i++)
      push_cmd(OP_READ, 16'($urandom), 24'($urandom),
               ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, wlen - 1)));
  endtask

  initial begin
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.opcode = '0; in_ch.frame_number = '0;
    in_ch.gci_position = '0; in_ch.read_index = '0;
    out_ch.ready = 1'b0;
    sig_len = SIGNAL_LENGTH_RST; frm_cnt = FRAME_COUNT_RST; frm_len = FRAME_LENGTH_RST;
    lp_ord = LP_ORDER_RST; pos_q = POS_QUOT_RST; dur_q = DUR_QUOT_RST;
    foreach (wstore[i]) wstore[i] = '0;
    win_lo = 0; win_hi = 0; prev_gci = 0; gci_seen = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(negedge clk_i);

    // Directed: reset defaults, frame 0 has a window starting below zero.
    push_cmd(OP_READ, '0, '0, 10'd0);
    push_cmd(OP_READ, 16'hFFFF, 24'hFF_FFFF, 10'h3FF);
    push_cmd(OP_START, 16'd0, '0, '0);
    push_cmd(OP_GCI, '0, 24'd500, '0);
    push_cmd(OP_GCI, '0, 24'd10, '0);
    push_cmd(OP_READ, '0, '0, 10'd0);
    push_cmd(OP_GCI, '0, 24'd10, '0);
    push_cmd(OP_GCI, '0, 24'd5, '0);
    push_cmd(OP_GCI, '0, 24'd90, '0);
    push_cmd(OP_GCI, '0, 24'd199, '0);
    push_cmd(OP_UNUSED, 16'hFFFF, 24'hFF_FFFF, 10'h3FF);
    for (int i = 0; i < 8; i++) push_cmd(OP_READ, '0, '0, 10'(i * 30 + 205));
    push_cmd(OP_START, 16'hFFFF, '0, '0);
    push_cmd(OP_GCI, '0, 24'hFF_FFFF, '0);
    push_cmd(OP_READ, '0, '0, 10'd3);

    set_all(24'hFF_FFFF, 16'hFFFF, 10'd992, 6'd32, 17'd0, 17'd65536);
    repeat (4) gen_frame();
    set_all(24'd1, 16'd1, 10'd2, 6'd0, 17'd65536, 17'd65536);
    repeat (3) gen_frame();
    set_all(24'd100000, 16'd0, 10'd1, 6'd5, 17'h1FFFF, 17'h1FFFF);
    repeat (2) gen_frame();
    set_all(24'd8000, 16'd40, 10'h3FF, 6'h3F, 17'd6000, 17'd0);
    repeat (3) gen_frame();
    set_all(24'd16000, 16'd100, 10'd400, 6'd30, 17'd3277, 17'd45875);
    repeat (4) gen_frame();
    while (n_items < TARGET_ITEMS) begin
      set_all(24'($urandom_range(1000, 2000000)), 16'($urandom_range(10, 5000)),
              10'($urandom_range(2, 992)), 6'($urandom_range(0, 32)),
              17'($urandom_range(0, 30000)), 17'($urandom_range(0, 65536)));
      repeat (4) gen_frame();
    end

    wait_idle();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
